// ===== rtl/core/gedc_pkg.sv =====
`default_nettype none

package gedc_pkg;

    // Default node limit
    localparam int MAX_NODES_DEF = 1024;

    // Field widths
    localparam int ID_W   = 16;
    localparam int DEG_W  = 11;
    localparam int NCNT_W = 11;
    localparam int ECNT_W = 20;
    localparam int DSUM_W = 21;

    // Edge bitmap word: at most 2**EDGE_SEL_MAX bits per word
    localparam int EDGE_SEL_MAX = 5;

    // Queue depths
    localparam int CMD_DEPTH = 2;
    localparam int RES_DEPTH = 2;
    localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

    // Classified request, front to back
    typedef struct packed {
        logic            rejected;
        logic            self_loop;
        logic [ID_W-1:0] lo;
        logic [ID_W-1:0] hi;
    } cmd_t;

    // Result item, back to output queue
    typedef struct packed {
        logic              is_new_edge;
        logic              rejected;
        logic [ID_W-1:0]   low_node;
        logic [ID_W-1:0]   high_node;
        logic [DEG_W-1:0]  low_degree;
        logic [DEG_W-1:0]  high_degree;
        logic [NCNT_W-1:0] node_count;
        logic [ECNT_W-1:0] edge_count;
        logic [DSUM_W-1:0] degree_sum;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/gedc_ram.sv =====
`default_nettype none

module gedc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port (old data on collision)
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/gedc_fifo.sv =====
`default_nettype none

module gedc_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = gedc_pkg::CMD_DEPTH
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       push,
    input  wire logic [WIDTH-1:0]           push_data,
    input  wire logic                       pop,
    output logic      [WIDTH-1:0]           pop_data,
    output logic                            full,
    output logic                            empty,
    output logic [$clog2(DEPTH+1)-1:0]      count
);

    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNTW-1:0]  count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == CNTW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign count    = count_reg;
    assign pop_data = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNTW'(1);
            2'b01:   count_next = count_reg - CNTW'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/gedc_front.sv =====
`default_nettype none

module gedc_front #(
    parameter int MAX_NODES = gedc_pkg::MAX_NODES_DEF
) (
    input  wire logic                        push,
    input  wire logic [gedc_pkg::ID_W-1:0]   node_a,
    input  wire logic [gedc_pkg::ID_W-1:0]   node_b,
    input  wire logic                        clearing,
    input  wire logic                        cmd_full,
    output logic                             full,
    output logic                             cmd_push,
    output gedc_pkg::cmd_t                   cmd
);

    localparam logic [gedc_pkg::ID_W-1:0] LIMIT = gedc_pkg::ID_W'(MAX_NODES);

    // No requests while the memories are being cleared
    assign full     = cmd_full || clearing;
    assign cmd_push = push && !full;

    // Order the endpoints and classify
    always_comb
    begin
        if (node_a < node_b)
        begin
            cmd.lo = node_a;
            cmd.hi = node_b;
        end
        else
        begin
            cmd.lo = node_b;
            cmd.hi = node_a;
        end
        cmd.rejected  = (cmd.hi >= LIMIT);
        cmd.self_loop = (node_a == node_b);
    end

endmodule

`default_nettype wire

// ===== rtl/core/gedc_back.sv =====
`default_nettype none

module gedc_back #(
    parameter int MAX_NODES = gedc_pkg::MAX_NODES_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cmd_empty,
    input  wire gedc_pkg::cmd_t                  cmd,
    output logic                                 cmd_pop,
    input  wire logic [gedc_pkg::RES_CNT_W-1:0]  res_count,
    output logic                                 res_push,
    output gedc_pkg::res_t                       res,
    output logic                                 clearing
);

    localparam int DEG_W  = gedc_pkg::DEG_W;
    localparam int NCNT_W = gedc_pkg::NCNT_W;
    localparam int ECNT_W = gedc_pkg::ECNT_W;
    localparam int DSUM_W = gedc_pkg::DSUM_W;
    localparam int NW     = $clog2(MAX_NODES);
    localparam int SEL_W  = (2 * NW > gedc_pkg::EDGE_SEL_MAX) ?
                            gedc_pkg::EDGE_SEL_MAX : 2 * NW - 1;
    localparam int ADDR_W = 2 * NW - SEL_W;
    localparam int EWW    = 1 << SEL_W;
    localparam int CW     = (ADDR_W > NW) ? ADDR_W : NW;
    localparam int DWW    = DEG_W + 1;
    localparam int CMPW   = gedc_pkg::RES_CNT_W + 1;

    // Clearing sweep
    logic          clearing_reg, clearing_next;
    logic [CW-1:0] clr_cnt_reg, clr_cnt_next;

    // Phase registers: B (edge bit and low degree back), C (high degree back)
    logic           b_valid_reg, c_valid_reg;
    gedc_pkg::cmd_t b_cmd_reg, c_cmd_reg;
    logic           c_new_reg;
    logic [DWW-1:0] c_lo_word_reg;
    logic [DEG_W-1:0] c_lo_deg_reg;

    // Write forwarding for the degree memory
    logic           fwd_valid_reg;
    logic [NW-1:0]  fwd_addr_reg;
    logic [DWW-1:0] fwd_data_reg;

    // Running totals
    logic [NCNT_W-1:0] node_cnt_reg, node_cnt_next;
    logic [ECNT_W-1:0] edge_cnt_reg, edge_cnt_next;
    logic [DSUM_W-1:0] deg_sum_reg, deg_sum_next;

    // Memory ports
    logic              edge_we;
    logic [ADDR_W-1:0] edge_waddr, edge_raddr;
    logic [EWW-1:0]    edge_wdata, edge_rdata;
    logic              deg_we;
    logic [NW-1:0]     deg_waddr, deg_raddr;
    logic [DWW-1:0]    deg_wdata, deg_rdata;

    // Address pieces
    logic [NW-1:0]     a_lo, a_hi, b_lo, b_hi, c_lo, c_hi;
    logic [2*NW-1:0]   a_eidx, b_eidx;
    logic [SEL_W-1:0]  b_sel;
    logic              start;

    // Phase B logic
    logic [DWW-1:0]   b_lo_word;
    logic             b_new;
    logic [DEG_W-1:0] b_lo_inc, b_lo_deg_new, b_lo_deg_rep;

    // Phase C logic
    logic [DWW-1:0]    c_hi_word;
    logic [DEG_W-1:0]  c_hi_deg_new, c_hi_deg_rep;
    logic              c_hi_wr;
    logic [1:0]        c_node_inc;

    assign clearing = clearing_reg;

    assign a_lo   = cmd.lo[NW-1:0];
    assign a_hi   = cmd.hi[NW-1:0];
    assign b_lo   = b_cmd_reg.lo[NW-1:0];
    assign b_hi   = b_cmd_reg.hi[NW-1:0];
    assign c_lo   = c_cmd_reg.lo[NW-1:0];
    assign c_hi   = c_cmd_reg.hi[NW-1:0];
    assign a_eidx = {a_lo, a_hi};
    assign b_eidx = {b_lo, b_hi};
    assign b_sel  = b_eidx[SEL_W-1:0];

    // Start a request: phase A may overlap phase C, never phase B; reserve result room
    assign start = !cmd_empty && !b_valid_reg && !clearing_reg &&
                   ((CMPW'(res_count) + CMPW'(c_valid_reg)) < CMPW'(gedc_pkg::RES_DEPTH));
    assign cmd_pop = start;

    // Read addresses: edge word and low degree in phase A, high degree in phase B
    assign edge_raddr = a_eidx[2*NW-1:SEL_W];
    assign deg_raddr  = b_valid_reg ? b_hi : a_lo;

    // Phase B: test edge bit, update low endpoint
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == b_lo))
        begin
            b_lo_word = fwd_data_reg;
        end
        else
        begin
            b_lo_word = deg_rdata;
        end
        b_new        = !b_cmd_reg.rejected && !edge_rdata[b_sel];
        b_lo_inc     = b_cmd_reg.self_loop ? DEG_W'(2) : DEG_W'(1);
        b_lo_deg_new = b_lo_word[DEG_W-1:0] + b_lo_inc;
        if (b_cmd_reg.rejected)
        begin
            b_lo_deg_rep = '0;
        end
        else if (b_new)
        begin
            b_lo_deg_rep = b_lo_deg_new;
        end
        else
        begin
            b_lo_deg_rep = b_lo_word[DEG_W-1:0];
        end
    end

    // Phase C: update high endpoint and totals
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == c_hi))
        begin
            c_hi_word = fwd_data_reg;
        end
        else
        begin
            c_hi_word = deg_rdata;
        end
        c_hi_deg_new = c_hi_word[DEG_W-1:0] + DEG_W'(1);
        c_hi_wr      = c_valid_reg && c_new_reg && !c_cmd_reg.self_loop;
        if (c_cmd_reg.rejected)
        begin
            c_hi_deg_rep = '0;
        end
        else if (c_cmd_reg.self_loop)
        begin
            c_hi_deg_rep = c_lo_deg_reg;
        end
        else if (c_new_reg)
        begin
            c_hi_deg_rep = c_hi_deg_new;
        end
        else
        begin
            c_hi_deg_rep = c_hi_word[DEG_W-1:0];
        end

        if (c_new_reg)
        begin
            c_node_inc = {1'b0, !c_lo_word_reg[DEG_W]} +
                         {1'b0, !c_cmd_reg.self_loop && !c_hi_word[DEG_W]};
        end
        else
        begin
            c_node_inc = 2'd0;
        end

        node_cnt_next = node_cnt_reg;
        edge_cnt_next = edge_cnt_reg;
        deg_sum_next  = deg_sum_reg;
        if (c_valid_reg)
        begin
            node_cnt_next = node_cnt_reg + NCNT_W'(c_node_inc);
            if (c_new_reg)
            begin
                edge_cnt_next = edge_cnt_reg + ECNT_W'(1);
                deg_sum_next  = deg_sum_reg + DSUM_W'(2);
            end
        end
    end

    // Edge bitmap write: clear sweep or set the new edge's bit
    always_comb
    begin
        if (clearing_reg)
        begin
            edge_we    = 1'b1;
            edge_waddr = clr_cnt_reg[ADDR_W-1:0];
            edge_wdata = '0;
        end
        else
        begin
            edge_we    = b_valid_reg && b_new;
            edge_waddr = b_eidx[2*NW-1:SEL_W];
            edge_wdata = edge_rdata | (EWW'(1) << b_sel);
        end
    end

    // Degree write: clear sweep, low endpoint in B, high endpoint in C
    always_comb
    begin
        if (clearing_reg)
        begin
            deg_we    = 1'b1;
            deg_waddr = clr_cnt_reg[NW-1:0];
            deg_wdata = '0;
        end
        else if (b_valid_reg && b_new)
        begin
            deg_we    = 1'b1;
            deg_waddr = b_lo;
            deg_wdata = {1'b1, b_lo_deg_new};
        end
        else if (c_hi_wr)
        begin
            deg_we    = 1'b1;
            deg_waddr = c_hi;
            deg_wdata = {1'b1, c_hi_deg_new};
        end
        else
        begin
            deg_we    = 1'b0;
            deg_waddr = b_lo;
            deg_wdata = '0;
        end
    end

    // Clear sweep sequencing
    always_comb
    begin
        clearing_next = clearing_reg;
        clr_cnt_next  = clr_cnt_reg;
        if (clearing_reg)
        begin
            clr_cnt_next = clr_cnt_reg + CW'(1);
            if (clr_cnt_reg == '1)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    // Result
    always_comb
    begin
        res.is_new_edge = c_new_reg;
        res.rejected    = c_cmd_reg.rejected;
        res.low_node    = c_cmd_reg.lo;
        res.high_node   = c_cmd_reg.hi;
        res.low_degree  = c_lo_deg_reg;
        res.high_degree = c_hi_deg_rep;
        res.node_count  = node_cnt_next;
        res.edge_count  = edge_cnt_next;
        res.degree_sum  = deg_sum_next;
    end
    assign res_push = c_valid_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            node_cnt_reg  <= '0;
            edge_cnt_reg  <= '0;
            deg_sum_reg   <= '0;
        end
        else
        begin
            clearing_reg  <= clearing_next;
            clr_cnt_reg   <= clr_cnt_next;
            b_valid_reg   <= start;
            c_valid_reg   <= b_valid_reg;
            fwd_valid_reg <= deg_we;
            node_cnt_reg  <= node_cnt_next;
            edge_cnt_reg  <= edge_cnt_next;
            deg_sum_reg   <= deg_sum_next;
        end
    end

    // Payload pipeline
    always_ff @(posedge clk)
    begin
        b_cmd_reg     <= cmd;
        c_cmd_reg     <= b_cmd_reg;
        c_new_reg     <= b_new;
        c_lo_word_reg <= b_lo_word;
        c_lo_deg_reg  <= b_lo_deg_rep;
        fwd_addr_reg  <= deg_waddr;
        fwd_data_reg  <= deg_wdata;
    end

    // Edge-seen bitmap
    gedc_ram #(
        .WIDTH (EWW),
        .DEPTH (1 << ADDR_W)
    ) u_edge_ram (
        .clk   (clk),
        .we    (edge_we),
        .waddr (edge_waddr),
        .wdata (edge_wdata),
        .raddr (edge_raddr),
        .rdata (edge_rdata)
    );

    // Node seen flag and degree
    gedc_ram #(
        .WIDTH (DWW),
        .DEPTH (1 << NW)
    ) u_deg_ram (
        .clk   (clk),
        .we    (deg_we),
        .waddr (deg_waddr),
        .wdata (deg_wdata),
        .raddr (deg_raddr),
        .rdata (deg_rdata)
    );

endmodule

`default_nettype wire

// ===== rtl/core/graph_edge_dedup_degree_count_core.sv =====
// Path: an accepted request passes the request queue, then phases A, B and C of the back end,
// and its result then enters the result queue. A request may start phase A while the one
// before it is in phase C, but not while it is in phase B; each request makes two reads and up
// to two writes on the single-port-pair degree memory (low endpoint, then high endpoint).
// Reset: rst_n clears all control state and starts a clearing sweep over the edge bitmap
// and degree memory; full stays high during the sweep.
`default_nettype none

module graph_edge_dedup_degree_count_core #(
    parameter int MAX_NODES = gedc_pkg::MAX_NODES_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [gedc_pkg::ID_W-1:0]     node_a,
    input  wire logic [gedc_pkg::ID_W-1:0]     node_b,
    output logic                               empty,
    input  wire logic                          pop,
    output logic                               is_new_edge,
    output logic                               rejected,
    output logic [gedc_pkg::ID_W-1:0]          low_node,
    output logic [gedc_pkg::ID_W-1:0]          high_node,
    output logic [gedc_pkg::DEG_W-1:0]         low_degree,
    output logic [gedc_pkg::DEG_W-1:0]         high_degree,
    output logic [gedc_pkg::NCNT_W-1:0]        node_count,
    output logic [gedc_pkg::ECNT_W-1:0]        edge_count,
    output logic [gedc_pkg::DSUM_W-1:0]        degree_sum
);

    localparam int CMD_W = $bits(gedc_pkg::cmd_t);
    localparam int RES_W = $bits(gedc_pkg::res_t);

    logic                           clearing;
    logic                           cmd_push, cmd_pop, cmd_full, cmd_empty;
    gedc_pkg::cmd_t                 cmd_in, cmd_head;
    logic [CMD_W-1:0]               cmd_raw;
    logic                           res_push, res_full;
    logic [gedc_pkg::RES_CNT_W-1:0] res_count;
    gedc_pkg::res_t                 res_in, res_head;
    logic [RES_W-1:0]               res_raw;

    // Front: order and classify requests
    gedc_front #(
        .MAX_NODES (MAX_NODES)
    ) u_front (
        .push     (push),
        .node_a   (node_a),
        .node_b   (node_b),
        .clearing (clearing),
        .cmd_full (cmd_full),
        .full     (full),
        .cmd_push (cmd_push),
        .cmd      (cmd_in)
    );

    // Request queue between front and back
    gedc_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (gedc_pkg::CMD_DEPTH)
    ) u_cmd_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .push_data (cmd_in),
        .pop       (cmd_pop),
        .pop_data  (cmd_raw),
        .full      (cmd_full),
        .empty     (cmd_empty),
        .count     ()
    );
    assign cmd_head = gedc_pkg::cmd_t'(cmd_raw);

    // Back: bitmap and degree read-modify-write
    gedc_back #(
        .MAX_NODES (MAX_NODES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd       (cmd_head),
        .cmd_pop   (cmd_pop),
        .res_count (res_count),
        .res_push  (res_push),
        .res       (res_in),
        .clearing  (clearing)
    );

    // Result queue
    gedc_fifo #(
        .WIDTH (RES_W),
        .DEPTH (gedc_pkg::RES_DEPTH)
    ) u_res_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_push),
        .push_data (res_in),
        .pop       (pop),
        .pop_data  (res_raw),
        .full      (res_full),
        .empty     (empty),
        .count     (res_count)
    );
    assign res_head = gedc_pkg::res_t'(res_raw);

    assign is_new_edge = res_head.is_new_edge;
    assign rejected    = res_head.rejected;
    assign low_node    = res_head.low_node;
    assign high_node   = res_head.high_node;
    assign low_degree  = res_head.low_degree;
    assign high_degree = res_head.high_degree;
    assign node_count  = res_head.node_count;
    assign edge_count  = res_head.edge_count;
    assign degree_sum  = res_head.degree_sum;

    // Result credit must never overrun the result queue
    assert property (@(posedge clk) disable iff (!rst_n) res_push |-> !res_full)
        else $error("result queue overrun");

    // No request starts during the clearing sweep
    assert property (@(posedge clk) disable iff (!rst_n) clearing |-> !cmd_pop)
        else $error("request started while clearing");

    // Degree sum tracks twice the edge count
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (degree_sum == {edge_count, 1'b0}))
        else $error("degree sum out of step with edge count");

    // A self-loop reports one degree for both endpoints
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !rejected && (low_node == high_node)) |-> (low_degree == high_degree))
        else $error("self-loop degrees differ");

endmodule

`default_nettype wire
